// File: hdl/heartbeat_frame_spacing_scheduler_defines.svh
// ----------------------------------------------------------------------------
// heartbeat_frame_spacing_scheduler_defines
// assertion macros shared by the scheduler rtl
// ----------------------------------------------------------------------------
`ifndef HEARTBEAT_FRAME_SPACING_SCHEDULER_DEFINES_SVH
`define HEARTBEAT_FRAME_SPACING_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define HFSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HFSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/hfss_pkg.sv
// ----------------------------------------------------------------------------
// hfss_pkg
// types and constants of the heartbeat and frame spacing scheduler
// ----------------------------------------------------------------------------
package hfss_pkg;

  localparam int TIME_W   = 32;
  localparam int SPAN_W   = 10;
  localparam int MASK_W   = 4;
  localparam int ADDR_W   = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [SPAN_W-1:0] RST_PERIOD  = SPAN_W'(20);
  localparam logic [SPAN_W-1:0] RST_SPACING = SPAN_W'(10);
  localparam logic [TIME_W-1:0] RST_LAST_TX = TIME_W'(0) - TIME_W'(RST_SPACING);
  localparam logic [TIME_W-1:0] RST_LAST_HB = TIME_W'(0) - TIME_W'(RST_PERIOD);

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE_MASK = 2'd0,
    REG_HB_PERIOD   = 2'd1,
    REG_SPACING     = 2'd2
  } reg_idx_t;

  // broadcast to every cell
  typedef struct packed {
    logic              tick;
    logic              req;
    logic              accepts;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] now;
    logic [SPAN_W-1:0] period;
    logic [SPAN_W-1:0] spacing;
  } bcast_t;

  // handed from cell to cell
  typedef struct packed {
    logic              hb_taken;
    logic              req_blocked;
    logic [ADDR_W-1:0] hb_id;
  } chain_t;

endpackage

// File: hdl/hfss_cell.sv
// ----------------------------------------------------------------------------
// hfss_cell
// one controller: timestamps, elapsed checks and link in the priority chain
// ----------------------------------------------------------------------------
module hfss_cell #(
  parameter logic [7:0] CELL_ADDR = 8'h11
) (
  input  logic            clk,
  input  logic            rst_n,
  input  hfss_pkg::bcast_t bc,
  input  logic            enable,
  input  hfss_pkg::chain_t chain_i,
  output hfss_pkg::chain_t chain_o
);

  logic [hfss_pkg::TIME_W-1:0] last_tx_r, last_tx_nxt;
  logic [hfss_pkg::TIME_W-1:0] last_hb_r, last_hb_nxt;
  logic [hfss_pkg::TIME_W-1:0] tx_age, hb_age;
  logic tx_ok, hb_ok, eligible, pick, match;

  always_comb begin
    tx_age   = bc.now - last_tx_r;
    hb_age   = bc.now - last_hb_r;
    tx_ok    = tx_age >= hfss_pkg::TIME_W'(bc.spacing);
    hb_ok    = hb_age >= hfss_pkg::TIME_W'(bc.period);
    eligible = enable & hb_ok & tx_ok;
    pick     = eligible & ~chain_i.hb_taken;
    match    = (bc.addr == CELL_ADDR);

    chain_o.hb_taken    = chain_i.hb_taken | eligible;
    chain_o.req_blocked = chain_i.req_blocked | (match & ~tx_ok);
    chain_o.hb_id       = pick ? CELL_ADDR : chain_i.hb_id;

    last_tx_nxt = last_tx_r;
    last_hb_nxt = last_hb_r;
    if (bc.tick && pick) begin
      last_hb_nxt = bc.now;
      if (bc.accepts) begin
        last_tx_nxt = bc.now;
      end
    end
    if (bc.req && match && tx_ok) begin
      last_tx_nxt = bc.now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_tx_r <= hfss_pkg::RST_LAST_TX;
      last_hb_r <= hfss_pkg::RST_LAST_HB;
    end else begin
      last_tx_r <= last_tx_nxt;
      last_hb_r <= last_hb_nxt;
    end
  end

endmodule

// File: hdl/heartbeat_frame_spacing_scheduler.sv
// ----------------------------------------------------------------------------
// heartbeat_frame_spacing_scheduler
// heartbeat and frame spacing scheduler for a row of can controllers
// ----------------------------------------------------------------------------
// Takes one beat per clock while in_tready is high, and returns exactly one
// registered result per input beat. All elapsed checks and the priority pick
// run through the row of controller cells in the accept cycle, so the state
// is current for the very next beat. A two-entry output buffer (output
// register plus skid) keeps in_tready registered and lets a new beat enter
// while a result waits; in_tready drops only while both entries are full.
// Tick beats (opcode 0) advance the millisecond counter and may send one
// heartbeat to controller BASE_ADDRESS + i; send beats (opcode 1) are
// granted or refused by the per-controller spacing check.
// ----------------------------------------------------------------------------
`include "heartbeat_frame_spacing_scheduler_defines.svh"

module heartbeat_frame_spacing_scheduler #(
  parameter int NUM_CONTROLLERS = 4,
  parameter int BASE_ADDRESS    = 17
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // target_address[7:0], bus_accepts[8], zeros
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // frame_attempted[0], frame_sent[1],
                                  // frame_id[9:2], request_granted[10],
                                  // failure_count[42:11], zeros
  output logic        out_tuser,  // is_heartbeat
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_wdata
);

  localparam int RES_W = 44;

  logic [hfss_pkg::MASK_W-1:0] mask_r;
  logic [hfss_pkg::SPAN_W-1:0] period_r, spacing_r;
  logic [hfss_pkg::TIME_W-1:0] tick_r, tick_nxt, fail_r, fail_nxt;

  logic in_fire, out_fire, hb_fail;
  hfss_pkg::bcast_t bc;
  hfss_pkg::chain_t chain [NUM_CONTROLLERS+1];

  logic attempted, sent, granted, is_hb;
  logic [hfss_pkg::ADDR_W-1:0] fid;
  logic [RES_W-1:0] res;

  logic             out_valid_r, skid_valid_r;
  logic [RES_W-1:0] out_r, skid_r;

  assign in_fire  = in_tvalid & in_tready;
  assign out_fire = out_valid_r & out_tready;

  always_comb begin
    bc.tick    = in_fire & (in_tuser == hfss_pkg::OP_TICK);
    bc.req     = in_fire & (in_tuser == hfss_pkg::OP_SEND);
    bc.accepts = in_tdata[8];
    bc.addr    = in_tdata[7:0];
    bc.now     = (in_tuser == hfss_pkg::OP_TICK) ? tick_r + 1'b1 : tick_r;
    bc.period  = period_r;
    bc.spacing = spacing_r;
  end

  assign chain[0] = '{hb_taken: 1'b0, req_blocked: 1'b0, hb_id: '0};

  for (genvar i = 0; i < NUM_CONTROLLERS; i++) begin : g_cell
    logic en;
    if (i < hfss_pkg::MASK_W) begin : g_en
      assign en = mask_r[i];
    end else begin : g_off
      assign en = 1'b0;
    end
    hfss_cell #(
      .CELL_ADDR(8'(BASE_ADDRESS + i))
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .bc     (bc),
      .enable (en),
      .chain_i(chain[i]),
      .chain_o(chain[i+1])
    );
  end

  always_comb begin
    is_hb     = bc.tick & chain[NUM_CONTROLLERS].hb_taken;
    granted   = bc.req & ~chain[NUM_CONTROLLERS].req_blocked;
    attempted = is_hb | granted;
    sent      = attempted & bc.accepts;
    fid       = is_hb ? chain[NUM_CONTROLLERS].hb_id : (granted ? bc.addr : '0);
    hb_fail   = is_hb & ~bc.accepts;
    tick_nxt  = bc.tick ? bc.now : tick_r;
    fail_nxt  = hb_fail ? fail_r + 1'b1 : fail_r;
    res       = {is_hb, fail_nxt, granted, fid, sent, attempted};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      fail_r <= '0;
    end else begin
      tick_r <= tick_nxt;
      fail_r <= fail_nxt;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r    <= '0;
      period_r  <= hfss_pkg::RST_PERIOD;
      spacing_r <= hfss_pkg::RST_SPACING;
    end else if (cfg_we) begin
      unique case (hfss_pkg::reg_idx_t'(cfg_index))
        hfss_pkg::REG_ENABLE_MASK: mask_r    <= cfg_wdata[hfss_pkg::MASK_W-1:0];
        hfss_pkg::REG_HB_PERIOD:   period_r  <= cfg_wdata;
        hfss_pkg::REG_SPACING:     spacing_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_fire) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (out_valid_r && !out_fire && in_fire) begin
      skid_r <= res;
    end
  end

  assign in_tready  = ~skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_r[RES_W-2:0]};
  assign out_tuser  = out_r[RES_W-1];

  `HFSS_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r, "skid full with empty output register")
  `HFSS_ASSERT_NEXT(a_fail_hold, clk, rst_n, !hb_fail, fail_r == $past(fail_r), "failure count moved without a failed heartbeat")
  `HFSS_ASSERT_NEXT(a_tick_step, clk, rst_n, bc.tick, tick_r == $past(tick_r) + 1'b1, "tick counter did not advance by one")
  `HFSS_ASSERT_NOW(a_hb_not_grant, clk, rst_n, out_valid_r && out_tuser, out_tdata[0] && !out_tdata[10], "heartbeat result marked as granted request")

endmodule

// File: verif/heartbeat_frame_spacing_scheduler_checker.sv
// ----------------------------------------------------------------------------
// heartbeat_frame_spacing_scheduler_checker
// watches the scheduler channels, predicts each decision and compares
// ----------------------------------------------------------------------------
// Follows the register writes and every accepted input beat, keeps its own
// copy of the tick counter and the per-controller stamps, and queues the
// decision it expects for each beat. Each accepted result beat is compared
// field by field with the oldest queued decision.
// ----------------------------------------------------------------------------
module heartbeat_frame_spacing_scheduler_checker
  import hfss_pkg::*;
#(
  parameter int NUM_CONTROLLERS = 4,
  parameter int BASE_ADDRESS    = 17
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // target_address[7:0], bus_accepts[8], zeros
  input  logic        in_tuser,   // opcode
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // frame_attempted[0], frame_sent[1],
                                  // frame_id[9:2], request_granted[10],
                                  // failure_count[42:11], zeros
  input  logic        out_tuser,  // is_heartbeat
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          checked,
  output int          heartbeats,
  output int          refusals
);

  typedef struct packed {
    logic              attempted;
    logic              sent;
    logic [ADDR_W-1:0] frame_id;
    logic              heartbeat;
    logic              granted;
    logic [TIME_W-1:0] failures;
  } decision_t;

  logic [MASK_W-1:0] enable_mask;
  logic [SPAN_W-1:0] hb_period;
  logic [SPAN_W-1:0] spacing;
  logic [TIME_W-1:0] ms_now;
  logic [TIME_W-1:0] hb_fail_total;
  logic [TIME_W-1:0] last_tx [NUM_CONTROLLERS];
  logic [TIME_W-1:0] last_hb [NUM_CONTROLLERS];
  decision_t         due_decisions [$];

  function automatic logic span_passed(logic [TIME_W-1:0] now, logic [TIME_W-1:0] stamp,
                                       logic [SPAN_W-1:0] span);
    logic [TIME_W-1:0] age;
    age = now - stamp;
    return age >= TIME_W'(span);
  endfunction

  function automatic decision_t schedule_beat(logic op, logic [ADDR_W-1:0] addr,
                                              logic accepts);
    decision_t         d;
    logic [TIME_W-1:0] now;
    logic              done;
    int                hit;
    d    = '0;
    done = 1'b0;
    hit  = -1;
    if (op == OP_TICK) begin
      now    = ms_now + 1;
      ms_now = now;
      for (int i = 0; i < NUM_CONTROLLERS; i++) begin
        if (!done && i < MASK_W && enable_mask[i] &&
            span_passed(now, last_hb[i], hb_period) &&
            span_passed(now, last_tx[i], spacing)) begin
          done        = 1'b1;
          d.attempted = 1'b1;
          d.heartbeat = 1'b1;
          d.sent      = accepts;
          d.frame_id  = ADDR_W'(BASE_ADDRESS + i);
          if (accepts) last_tx[i] = now;
          else hb_fail_total = hb_fail_total + 1;
          last_hb[i] = now;
        end
      end
    end else begin
      for (int i = 0; i < NUM_CONTROLLERS; i++)
        if (hit < 0 && ADDR_W'(BASE_ADDRESS + i) == addr) hit = i;
      if (hit < 0 || span_passed(ms_now, last_tx[hit], spacing)) begin
        d.granted   = 1'b1;
        d.attempted = 1'b1;
        d.sent      = accepts;
        d.frame_id  = addr;
        if (hit >= 0) last_tx[hit] = ms_now;
      end
    end
    d.failures = hb_fail_total;
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("%0t: error: %s", $time, msg);
  endtask

  task automatic compare_field(input string field, input logic [TIME_W-1:0] got,
                               input logic [TIME_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                checked, field, got, want));
  endtask

  always @(posedge clk) begin
    decision_t want;
    decision_t got;
    if (!rst_n) begin
      enable_mask   = '0;
      hb_period     = RST_PERIOD;
      spacing       = RST_SPACING;
      ms_now        = '0;
      hb_fail_total = '0;
      for (int i = 0; i < NUM_CONTROLLERS; i++) begin
        last_tx[i] = RST_LAST_TX;
        last_hb[i] = RST_LAST_HB;
      end
      due_decisions.delete();
      fail_count = 0;
      checked    = 0;
      heartbeats = 0;
      refusals   = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.attempted = out_tdata[0];
        got.sent      = out_tdata[1];
        got.frame_id  = out_tdata[9:2];
        got.granted   = out_tdata[10];
        got.failures  = out_tdata[42:11];
        got.heartbeat = out_tuser;
        if (due_decisions.size() == 0) begin
          report_mismatch($sformatf("result beat 0x%0h with nothing expected", out_tdata));
        end else begin
          want = due_decisions.pop_front();
          compare_field("frame_attempted", TIME_W'(got.attempted), TIME_W'(want.attempted));
          compare_field("frame_sent", TIME_W'(got.sent), TIME_W'(want.sent));
          compare_field("frame_id", TIME_W'(got.frame_id), TIME_W'(want.frame_id));
          compare_field("is_heartbeat", TIME_W'(got.heartbeat), TIME_W'(want.heartbeat));
          compare_field("request_granted", TIME_W'(got.granted), TIME_W'(want.granted));
          compare_field("failure_count", got.failures, want.failures);
          checked++;
        end
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_ENABLE_MASK: enable_mask = cfg_wdata[MASK_W-1:0];
          REG_HB_PERIOD:   hb_period   = cfg_wdata;
          REG_SPACING:     spacing     = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        want = schedule_beat(in_tuser, in_tdata[7:0], in_tdata[8]);
        if (want.heartbeat) heartbeats++;
        if (in_tuser == OP_SEND && !want.granted) refusals++;
        due_decisions.push_back(want);
      end
    end
    pending = due_decisions.size();
  end

endmodule

// File: verif/heartbeat_frame_spacing_scheduler_test.sv
// ----------------------------------------------------------------------------
// heartbeat_frame_spacing_scheduler_test
// stimulus and verdict for the heartbeat and frame spacing scheduler
// ----------------------------------------------------------------------------
// Drives a directed set of ticks and send requests at the register extremes,
// then phases of random beats under random register settings, with random
// gaps on both channels, one long receiver hold-off that backs up the input
// and sender pauses until all results are back. The checker beside the
// block predicts and compares; this module reports the verdict.
// ----------------------------------------------------------------------------
module heartbeat_frame_spacing_scheduler_test;
  import hfss_pkg::*;

  localparam int NUM_CTRL   = 4;
  localparam int BASE_ADDR  = 17;
  localparam int ITEMS      = 1450;
  localparam int LIMIT      = 400000;
  localparam int HOLD_LEN   = 400;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // target_address[7:0], bus_accepts[8], zeros
  logic        in_tuser   = 1'b0; // opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;         // frame_attempted[0], frame_sent[1],
                                  // frame_id[9:2], request_granted[10],
                                  // failure_count[42:11], zeros
  logic        out_tuser;         // is_heartbeat
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [9:0]  cfg_wdata  = '0;

  int fail_count;
  int pending;
  int checked;
  int heartbeats;
  int refusals;

  bit idle_on     = 1'b1;
  bit input_up    = 1'b0;
  bit hold_req    = 1'b0;
  bit hold_done   = 1'b0;
  int beats_sent  = 0;
  int settings    = 0;
  int cycle_count = 0;

  always #1 clk = ~clk;

  heartbeat_frame_spacing_scheduler #(
    .NUM_CONTROLLERS(NUM_CTRL),
    .BASE_ADDRESS   (BASE_ADDR)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  heartbeat_frame_spacing_scheduler_checker #(
    .NUM_CONTROLLERS(NUM_CTRL),
    .BASE_ADDRESS   (BASE_ADDR)
  ) i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked),
    .heartbeats(heartbeats),
    .refusals  (refusals)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("heartbeat_frame_spacing_scheduler: mismatch");
      $finish;
    end
  end

  function automatic int draw_idle();
    if (!idle_on || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  task automatic offer_beat(input logic op, input logic [7:0] addr, input logic accepts);
    int gap;
    gap = draw_idle();
    if (gap > 0) begin
      if (input_up) begin
        in_tvalid <= 1'b0;
        input_up = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'b0, accepts, addr};
    input_up = 1'b1;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  // stop offering and wait until every result beat is back
  task automatic drain();
    if (input_up) begin
      in_tvalid <= 1'b0;
      input_up = 1'b0;
    end
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_config(input logic [3:0] mask, input logic [9:0] period,
                            input logic [9:0] spacing);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ENABLE_MASK;
    cfg_wdata <= 10'(mask);
    @(posedge clk);
    cfg_index <= REG_HB_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    cfg_index <= REG_SPACING;
    cfg_wdata <= spacing;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  function automatic logic [7:0] pick_address();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 8'(BASE_ADDR + $urandom_range(0, NUM_CTRL - 1));
    if (r == 6) return ($urandom_range(0, 1) != 0) ? 8'(BASE_ADDR - 1) : 8'(BASE_ADDR + NUM_CTRL);
    return 8'($urandom_range(0, 255));
  endfunction

  // result side
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        stall = HOLD_LEN;
        hold_done = 1'b1;
      end else begin
        stall = draw_idle();
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // input side
  initial begin
    int          phase;
    int          len;
    logic [3:0]  mask;
    logic [9:0]  period;
    logic [9:0]  spacing;
    phase = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: mask clear, so ticks send nothing
    offer_beat(OP_TICK, 8'h00, 1'b1);
    offer_beat(OP_SEND, 8'h11, 1'b1);
    offer_beat(OP_SEND, 8'h11, 1'b0);
    offer_beat(OP_SEND, 8'h00, 1'b1);
    offer_beat(OP_SEND, 8'hff, 1'b0);
    offer_beat(OP_SEND, 8'h14, 1'b0);

    // all enabled, short period, no spacing
    set_config(4'hf, 10'd3, 10'd0);
    offer_beat(OP_TICK, 8'hff, 1'b0);
    offer_beat(OP_TICK, 8'h00, 1'b1);
    offer_beat(OP_TICK, 8'h5a, 1'b0);
    offer_beat(OP_TICK, 8'ha5, 1'b1);
    offer_beat(OP_TICK, 8'h00, 1'b1);
    offer_beat(OP_SEND, 8'h12, 1'b1);
    offer_beat(OP_SEND, 8'h12, 1'b1);
    offer_beat(OP_SEND, 8'h10, 1'b1);
    offer_beat(OP_SEND, 8'h15, 1'b0);

    // period of one tick
    set_config(4'h1, 10'd1, 10'd0);
    offer_beat(OP_TICK, 8'h00, 1'b0);
    offer_beat(OP_TICK, 8'h00, 1'b1);

    // period and spacing of 1000, sparse mask
    set_config(4'ha, 10'd1000, 10'd1000);
    offer_beat(OP_TICK, 8'h00, 1'b1);
    offer_beat(OP_TICK, 8'h00, 1'b0);
    offer_beat(OP_SEND, 8'h13, 1'b1);
    offer_beat(OP_SEND, 8'h14, 1'b1);
    offer_beat(OP_SEND, 8'h14, 1'b1);

    while (beats_sent < ITEMS) begin
      phase++;
      mask = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 9))
        0:       period = 10'd1;
        1:       period = 10'd1000;
        default: period = 10'($urandom_range(1, 30));
      endcase
      case ($urandom_range(0, 9))
        0:       spacing = 10'd0;
        1:       spacing = 10'd1000;
        default: spacing = 10'($urandom_range(0, 25));
      endcase
      set_config(mask, period, spacing);
      idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 3) begin
        idle_on  = 1'b0;
        hold_req = 1'b1;
      end
      len = $urandom_range(30, 110);
      for (int n = 0; n < len; n++) begin
        if (n == len / 2 && (phase == 2 || $urandom_range(0, 3) == 0)) drain();
        offer_beat(logic'($urandom_range(0, 1)), pick_address(),
                   logic'($urandom_range(0, 4) != 0));
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d beats under %0d register settings, %0d results checked",
             beats_sent, settings, checked);
    $display("%0d heartbeats predicted, %0d send requests refused for spacing",
             heartbeats, refusals);
    if (fail_count == 0 && pending == 0) begin
      $display("heartbeat_frame_spacing_scheduler: match");
    end else begin
      $display("heartbeat_frame_spacing_scheduler: mismatch");
    end
    $finish;
  end

endmodule
